[sv/srr_pkg.sv]
// Shared types and constants for the swarm repulsion derivative core.
// No dependencies; imported by the top level only.
`timescale 1ns / 1ps

package srr_pkg;

   // round(1e-6 * 2^32), added to dx^2 in Q32.32
   localparam logic [63:0] EPS_Q32 = 64'd4295;
   localparam logic [30:0] MASK31  = 31'h7FFF_FFFF;

   // configuration register indexes
   localparam logic CSR_GAIN   = 1'b0;
   localparam logic CSR_CUTOFF = 1'b1;

   typedef struct packed {
      logic signed [31:0] position;
      logic signed [31:0] velocity;
      logic signed [31:0] env_force;
      logic               last_body;
   } req_type;

   typedef struct packed {
      logic        [5:0]  body_index;
      logic signed [31:0] position_rate;
      logic signed [31:0] velocity_rate;
      logic               saturated;
      logic               last_of_run;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD_I,
      ST_LATCH_I,
      ST_RD_J,
      ST_DX,
      ST_SQ,
      ST_SQRT_WAIT,
      ST_MUL,
      ST_DIV_WAIT,
      ST_FINISH
   } state_type;

endpackage

[sv/srr_sqrt.sv]
// Iterative floor square root of a 64-bit value, two radicand bits per cycle.
// Depends on nothing; used by the top level for the pair distance.
`timescale 1ns / 1ps

module srr_sqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] value,
   output logic        done,
   output logic [31:0] root
);

   logic [63:0] v_ff, res_ff, bit_ff;
   logic [4:0]  cnt_ff;
   logic        run_ff, done_ff;
   logic [63:0] trial;

   assign trial = res_ff + bit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
            v_ff   <= value;
            res_ff <= '0;
            bit_ff <= 64'd1 << 62;
         end else if (run_ff) begin
            if (v_ff >= trial) begin
               v_ff   <= v_ff - trial;
               res_ff <= (res_ff >> 1) + bit_ff;
            end else begin
               res_ff <= res_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign root = res_ff[31:0];

endmodule

[sv/srr_div.sv]
// Restoring divider, 62-bit dividend by 32-bit divisor, one quotient bit a cycle.
// Depends on nothing; used by the top level for the repulsion term.
`timescale 1ns / 1ps

module srr_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [61:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [61:0] quotient
);

   logic [61:0] qd_ff;
   logic [32:0] rem_ff;
   logic [31:0] dvs_ff;
   logic [5:0]  cnt_ff;
   logic        run_ff, done_ff;
   logic [32:0] shifted;
   logic        fits;

   assign shifted = {rem_ff[31:0], qd_ff[61]};
   assign fits    = shifted >= {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
            qd_ff  <= dividend;
            rem_ff <= '0;
            dvs_ff <= divisor;
         end else if (run_ff) begin
            rem_ff <= fits ? shifted - {1'b0, dvs_ff} : shifted;
            qd_ff  <= {qd_ff[60:0], fits};
            cnt_ff <= cnt_ff + 6'd1;
            if (cnt_ff == 6'd61) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = qd_ff;

endmodule

[sv/swarm_repulsion_rhs_core.sv]
// Top level: body store, pair scan sequencer and output register.
// Depends on srr_pkg, srr_sqrt and srr_div.
`timescale 1ns / 1ps
// During loading busy stays low, so a request is taken every cycle.
// On the last body busy rises; each body then scans all others, a pair at or beyond the
// cutoff using the sqrt alone, a repelling pair also the divide (32-step sqrt, 62-step divide).
// One result per body, strobed for one cycle; the receiver cannot stall.
// Sync reset clears state, body count, strobe; presets gain, cutoff; store is not cleared.

module swarm_repulsion_rhs_core
   import srr_pkg::*;
#(
   parameter int MAX_BODIES = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_data,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [30:0] csr_wdata,
   output logic        rsp_strobe,
   output rsp_type     rsp_data
);

   localparam int IW  = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;
   localparam int CW  = $clog2(MAX_BODIES + 1);
   localparam int IXW = (IW > 6) ? IW : 6;
   localparam logic [CW-1:0] MAXC = CW'(MAX_BODIES);

   state_type state_ff, state_in;

   logic [30:0]   gain_ff, cutoff_ff;
   logic [CW-1:0] count_ff, n_ff, i_ff, j_ff;
   logic [95:0]   mem [MAX_BODIES];
   logic [95:0]   rd_ff;
   logic [IW-1:0] rd_addr;
   logic signed [31:0] xi_ff, vi_ff, ei_ff;
   logic [31:0]   adx_ff;
   logic [63:0]   sq_value;
   logic [31:0]   dist_ff;
   logic [61:0]   dv_value;
   logic [30:0]   swarm_ff;
   logic          sat_ff;
   logic          sq_start, dv_start, sq_done, dv_done;
   logic [31:0]   root;
   logic [61:0]   quot;
   logic          accept;
   logic          rsp_strobe_ff;
   rsp_type       rsp_ff;

   logic signed [32:0] dx;
   logic [30:0]   term;
   logic          term_sat;
   logic [31:0]   swarm_sum;
   logic signed [33:0] total;
   logic [IXW-1:0] idx_ext;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);

   // store: written while loading, read every cycle, used only while scanning
   always_ff @(posedge clock) begin
      if (accept && (count_ff < MAXC))
         mem[count_ff[IW-1:0]] <= {req_data.position, req_data.velocity, req_data.env_force};
      rd_ff <= mem[rd_addr];
   end

   assign rd_addr = (state_ff == ST_RD_I) ? i_ff[IW-1:0] : j_ff[IW-1:0];

   // operands go straight into the units, which latch them on start
   assign sq_value = 64'(adx_ff) * 64'(adx_ff) + EPS_Q32;
   assign dv_value = 62'(gain_ff) * 62'(cutoff_ff - dist_ff[30:0]);

   srr_sqrt u_sqrt (
      .clock(clock), .reset(reset), .start(sq_start), .value(sq_value),
      .done(sq_done), .root(root)
   );

   srr_div u_div (
      .clock(clock), .reset(reset), .start(dv_start), .dividend(dv_value),
      .divisor(dist_ff), .done(dv_done), .quotient(quot)
   );

   assign dx        = 33'(xi_ff) - 33'($signed(rd_ff[95:64]));
   assign term_sat  = (quot > {31'd0, MASK31});
   assign term      = term_sat ? MASK31 : quot[30:0];
   assign swarm_sum = {1'b0, swarm_ff} + {1'b0, term};
   assign total     = 34'(ei_ff) + 34'(signed'({3'b000, swarm_ff}));
   assign idx_ext   = IXW'(i_ff);

   always_comb begin
      state_in = state_ff;
      sq_start = 1'b0;
      dv_start = 1'b0;
      unique case (state_ff)
         ST_IDLE:      if (accept && req_data.last_body) state_in = ST_RD_I;
         ST_RD_I:      state_in = ST_LATCH_I;
         ST_LATCH_I:   state_in = ST_RD_J;
         ST_RD_J: begin
            if (j_ff == n_ff)      state_in = ST_FINISH;
            else if (j_ff != i_ff) state_in = ST_DX;
         end
         ST_DX:        state_in = ST_SQ;
         ST_SQ: begin
            sq_start = 1'b1;
            state_in = ST_SQRT_WAIT;
         end
         ST_SQRT_WAIT: begin
            if (sq_done) state_in = (root >= {1'b0, cutoff_ff}) ? ST_RD_J : ST_MUL;
         end
         ST_MUL: begin
            dv_start = 1'b1;
            state_in = ST_DIV_WAIT;
         end
         ST_DIV_WAIT:  if (dv_done) state_in = ST_RD_J;
         ST_FINISH:    state_in = (i_ff + CW'(1) == n_ff) ? ST_IDLE : ST_RD_I;
         default:      state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         gain_ff       <= 31'd6554;
         cutoff_ff     <= 31'd65536;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= (state_ff == ST_FINISH);
         if (csr_we) begin
            if (csr_index == CSR_GAIN) gain_ff <= csr_wdata;
            else                       cutoff_ff <= csr_wdata;
         end
         if (accept) begin
            if (req_data.last_body) begin
               count_ff <= '0;
               n_ff     <= (count_ff < MAXC) ? count_ff + CW'(1) : count_ff;
               i_ff     <= '0;
            end else if (count_ff < MAXC) begin
               count_ff <= count_ff + CW'(1);
            end
         end
         unique case (state_ff)
            ST_LATCH_I: begin
               xi_ff    <= $signed(rd_ff[95:64]);
               vi_ff    <= $signed(rd_ff[63:32]);
               ei_ff    <= $signed(rd_ff[31:0]);
               swarm_ff <= '0;
               sat_ff   <= 1'b0;
               j_ff     <= '0;
            end
            ST_RD_J:      if (j_ff == i_ff) j_ff <= j_ff + CW'(1);
            ST_DX:        adx_ff <= dx[32] ? 32'(-dx) : dx[31:0];
            ST_SQRT_WAIT: begin
               if (sq_done) begin
                  dist_ff <= root;
                  if (root >= {1'b0, cutoff_ff}) j_ff <= j_ff + CW'(1);
               end
            end
            ST_DIV_WAIT: begin
               if (dv_done) begin
                  j_ff <= j_ff + CW'(1);
                  if (swarm_sum > {1'b0, MASK31}) begin
                     swarm_ff <= MASK31;
                     sat_ff   <= 1'b1;
                  end else begin
                     swarm_ff <= swarm_sum[30:0];
                     if (term_sat) sat_ff <= 1'b1;
                  end
               end
            end
            ST_FINISH: begin
               i_ff <= i_ff + CW'(1);
               rsp_ff.body_index    <= idx_ext[5:0];
               rsp_ff.position_rate <= vi_ff;
               rsp_ff.last_of_run   <= (i_ff + CW'(1) == n_ff);
               if (total > 34'sh0_7FFF_FFFF) begin
                  rsp_ff.velocity_rate <= 32'sh7FFF_FFFF;
                  rsp_ff.saturated     <= 1'b1;
               end else if (total < -34'sh0_8000_0000) begin
                  rsp_ff.velocity_rate <= 32'sh8000_0000;
                  rsp_ff.saturated     <= 1'b1;
               end else begin
                  rsp_ff.velocity_rate <= total[31:0];
                  rsp_ff.saturated     <= sat_ff;
               end
            end
            default: ;
         endcase
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   a_strobe_from_finish: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> $past(state_ff == ST_FINISH))
      else $error("response strobe without finish");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAXC)
      else $error("body count above store depth");
   a_sqrt_done_wait: assert property (@(posedge clock) disable iff (reset)
      sq_done |-> (state_ff == ST_SQRT_WAIT))
      else $error("sqrt done outside wait");
   a_div_done_wait: assert property (@(posedge clock) disable iff (reset)
      dv_done |-> (state_ff == ST_DIV_WAIT))
      else $error("divide done outside wait");
   a_scan_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DX) |-> (j_ff < n_ff && j_ff != i_ff))
      else $error("pair index out of range");

endmodule
